/* rtl/mbsa_pkg.sv */
// shared types and constants for the scaled 1-bpp bmp pixel address block
// no dependencies; compiled first
`default_nettype none

package mbsa_pkg;

  // display size used for the on-screen test
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;

  // field widths
  localparam int IMG_W    = 12;   // image width / height
  localparam int DEST_W   = 10;   // card size and destination index
  localparam int COORD_W  = 16;   // screen coordinates
  localparam int ADDR_W   = 32;   // file byte address
  localparam int BIT_W    = 3;    // bit within byte
  localparam int FRAC_W   = 8;    // fraction bits of the 12.8 step
  localparam int STEP_W   = IMG_W + FRAC_W;     // step before truncation to any range
  localparam int PROD_W   = DEST_W + STEP_W;    // index times step
  localparam int SRC_W    = PROD_W - FRAC_W;    // integer part of index times step
  localparam int RB_W     = 10;   // row length in bytes, at most 512
  localparam int ROWP_W   = IMG_W + RB_W;       // file row times row length
  localparam int DIV_CNT_W = $clog2(STEP_W);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd7;

  // settings seen by the address pipeline, sizes already forced to at least one
  typedef struct packed {
    logic [IMG_W-1:0]   iw;
    logic [IMG_W-1:0]   ih;
    logic [RB_W-1:0]    row_bytes;
    logic               bottom_up;
    logic [ADDR_W-1:0]  data_offset;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
  } cfg_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/mbsa_if.sv */
// valid/ready channel interfaces: destination pixel in, source address out
// depends on mbsa_pkg
`default_nettype none

interface mbsa_pix_if;
  import mbsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_col;
  logic [DEST_W-1:0] dest_row;

  modport source (output valid, dest_col, dest_row, input ready);
  modport sink   (input valid, dest_col, dest_row, output ready);
endinterface

interface mbsa_addr_if;
  import mbsa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ADDR_W-1:0]         byte_address;
  logic [BIT_W-1:0]          bit_select;
  logic signed [COORD_W-1:0] screen_x;
  logic signed [COORD_W-1:0] screen_y;
  logic                      on_screen;

  modport source (output valid, byte_address, bit_select, screen_x, screen_y, on_screen,
                  input ready);
  modport sink   (input valid, byte_address, bit_select, screen_x, screen_y, on_screen,
                  output ready);
endinterface

`default_nettype wire

/* rtl/mbsa_step_div.sv */
// restoring divider, one quotient bit per cycle, for the 12.8 scale steps
// depends on mbsa_pkg
`default_nettype none

module mbsa_step_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mbsa_pkg::STEP_W-1:0] dividend,
  input  wire logic [mbsa_pkg::DEST_W-1:0] divisor,
  output mbsa_pkg::div_stat_t             stat,
  output logic [mbsa_pkg::STEP_W-1:0]     quotient
);
  import mbsa_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DEST_W-1:0]     rem;
  logic [STEP_W-1:0]     quo;
  logic [DEST_W-1:0]     dvsr;
  logic [DEST_W:0]       trial;
  logic                  qbit;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[STEP_W-1]};
    qbit  = (trial >= {1'b0, dvsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(STEP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= qbit ? DEST_W'(trial - {1'b0, dvsr}) : trial[DEST_W-1:0];
      quo <= {quo[STEP_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

  // remainder stays below the divisor while iterating
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> rem < dvsr)
    else $error("divider remainder not below divisor");

  // a result is flagged only right after the last iteration
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without finishing");

endmodule

`default_nettype wire

/* rtl/mbsa_addr_pipe.sv */
// five-stage address pipeline: scale, clamp, flip, row multiply, final add
// depends on mbsa_pkg and mbsa_if
`default_nettype none

module mbsa_addr_pipe (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mbsa_pkg::cfg_t  cfg,
  input  wire logic            accept_en,
  mbsa_pix_if.sink             pix,
  mbsa_addr_if.source          addr
);
  import mbsa_pkg::*;

  // stage valids and advance terms
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage 1: index times step, screen position
  logic [PROD_W-1:0]  px1, py1;
  logic [COORD_W-1:0] sx1, sy1;
  // stage 2: clamped source position
  logic [IMG_W-1:0]   src_x2, src_y2;
  logic [COORD_W-1:0] sx2, sy2;
  logic               on2;
  // stage 3: file row
  logic [IMG_W-1:0]   src_x3, row3;
  logic [COORD_W-1:0] sx3, sy3;
  logic               on3;
  // stage 4: row offset product
  logic [ROWP_W-1:0]  rowp4;
  logic [IMG_W-4:0]   colb4;
  logic [BIT_W-1:0]   bit4;
  logic [COORD_W-1:0] sx4, sy4;
  logic               on4;
  // stage 5: output register
  logic [ADDR_W-1:0]  addr5;
  logic [BIT_W-1:0]   bit5;
  logic [COORD_W-1:0] sx5, sy5;
  logic               on5;

  logic [SRC_W-1:0]   sxi, syi;

  // backpressure chain
  assign adv5 = !v5 || addr.ready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pix.ready = adv1 && accept_en;

  // integer part of the scaled index
  assign sxi = px1[PROD_W-1:FRAC_W];
  assign syi = py1[PROD_W-1:FRAC_W];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= pix.valid && accept_en;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv1) begin
      px1 <= PROD_W'(pix.dest_col) * PROD_W'(cfg.step_x);
      py1 <= PROD_W'(pix.dest_row) * PROD_W'(cfg.step_y);
      sx1 <= cfg.origin_x + COORD_W'(pix.dest_col);
      sy1 <= cfg.origin_y + COORD_W'(pix.dest_row);
    end
  end

  // stage 2: clamp to the last column or row, on-screen test
  always_ff @(posedge clk) begin
    if (adv2) begin
      src_x2 <= (sxi >= SRC_W'(cfg.iw)) ? cfg.iw - 1'b1 : sxi[IMG_W-1:0];
      src_y2 <= (syi >= SRC_W'(cfg.ih)) ? cfg.ih - 1'b1 : syi[IMG_W-1:0];
      sx2    <= sx1;
      sy2    <= sy1;
      on2    <= !sx1[COORD_W-1] && (sx1 < COORD_W'(SCREEN_WIDTH)) &&
                !sy1[COORD_W-1] && (sy1 < COORD_W'(SCREEN_HEIGHT));
    end
  end

  // stage 3: flip the row for bottom-up storage
  always_ff @(posedge clk) begin
    if (adv3) begin
      src_x3 <= src_x2;
      row3   <= cfg.bottom_up ? cfg.ih - 1'b1 - src_y2 : src_y2;
      sx3    <= sx2;
      sy3    <= sy2;
      on3    <= on2;
    end
  end

  // stage 4: row offset, byte and bit within the row
  always_ff @(posedge clk) begin
    if (adv4) begin
      rowp4 <= ROWP_W'(row3) * ROWP_W'(cfg.row_bytes);
      colb4 <= src_x3[IMG_W-1:3];
      bit4  <= ~src_x3[BIT_W-1:0];
      sx4   <= sx3;
      sy4   <= sy3;
      on4   <= on3;
    end
  end

  // stage 5: final byte address
  always_ff @(posedge clk) begin
    if (adv5) begin
      addr5 <= cfg.data_offset + ADDR_W'(rowp4) + ADDR_W'(colb4);
      bit5  <= bit4;
      sx5   <= sx4;
      sy5   <= sy4;
      on5   <= on4;
    end
  end

  assign addr.valid        = v5;
  assign addr.byte_address = addr5;
  assign addr.bit_select   = bit5;
  assign addr.screen_x     = sx5;
  assign addr.screen_y     = sy5;
  assign addr.on_screen    = on5;

  // no word taken while the block is held off
  a_no_accept_held: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |-> accept_en)
    else $error("word accepted while input held off");

  // a stalled stage 1 keeps its word
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv2 |=> v1)
    else $error("stage 1 word lost under stall");

  // clamped source position lies inside the image
  a_src_in_image: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (src_x2 < cfg.iw) && (src_y2 < cfg.ih))
    else $error("source position outside image");

  // file row lies inside the image
  a_row_in_image: assert property (@(posedge clk) disable iff (rst)
    v3 |-> row3 < cfg.ih)
    else $error("file row outside image");

endmodule

`default_nettype wire

/* rtl/mono_bmp_scaled_pixel_address.sv */
// Scaled 1-bpp bmp pixel address generator, top level.
// Channels: pix (sink) takes one destination pixel word (dest_col, dest_row) per
// valid/ready handshake; addr (source) gives one word per pixel with the file
// byte address, bit select (7 = leftmost pixel), wrapped screen coordinates and
// an on-screen flag. Settings are written through cfg_we / cfg_index / cfg_data.
// The five-stage address pipeline takes a new word every cycle, one pixel per
// cycle, unless the addr receiver stalls it or a step recompute holds it off.
// The horizontal and vertical 12.8 steps come from a shared restoring divider,
// one quotient bit per cycle: a write to image or card width or height starts a
// recompute of both steps, and pix.ready stays low until it is done. Writes to
// other registers take effect at once. Reset loads the register defaults with
// both steps preset to 1.0, so pixels are taken in the cycle after reset with no
// wait. When the addr receiver stalls the pipeline fills, then pix.ready drops;
// nothing is lost or repeated.
// Depends on mbsa_pkg, mbsa_if, mbsa_step_div and mbsa_addr_pipe.
`default_nettype none

module mono_bmp_scaled_pixel_address (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbsa_pkg::CFG_DATA_W-1:0] cfg_data,
  mbsa_pix_if.sink                             pix,
  mbsa_addr_if.source                          addr
);
  import mbsa_pkg::*;

  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_X    = 2'd1;
  localparam logic [1:0] SEQ_Y    = 2'd2;

  // configuration registers
  logic [IMG_W-1:0]   image_width, image_height;
  logic               bottom_up;
  logic [ADDR_W-1:0]  data_offset;
  logic [DEST_W-1:0]  dest_width, dest_height;
  logic [COORD_W-1:0] origin_x, origin_y;

  // derived settings
  logic [IMG_W-1:0]   iw, ih;
  logic [DEST_W-1:0]  dw, dh;
  logic [IMG_W:0]     iw_round;
  logic [STEP_W-1:0]  step_x, step_y;
  logic               recalc;
  logic [1:0]         state, state_next;
  logic               size_write;

  // divider hookup
  logic               div_start;
  logic [STEP_W-1:0]  div_dividend;
  logic [DEST_W-1:0]  div_divisor;
  div_stat_t          div_stat;
  logic [STEP_W-1:0]  div_q;
  cfg_t               cfg;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W'(1);
      image_height <= IMG_W'(1);
      bottom_up    <= 1'b1;
      data_offset  <= '0;
      dest_width   <= DEST_W'(1);
      dest_height  <= DEST_W'(1);
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_W-1:0];
        REG_BOTTOM_UP:    bottom_up    <= cfg_data[0];
        REG_DATA_OFFSET:  data_offset  <= cfg_data[ADDR_W-1:0];
        REG_DEST_WIDTH:   dest_width   <= cfg_data[DEST_W-1:0];
        REG_DEST_HEIGHT:  dest_height  <= cfg_data[DEST_W-1:0];
        REG_ORIGIN_X:     origin_x     <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero size acts as one
  assign iw = (image_width  == '0) ? IMG_W'(1)  : image_width;
  assign ih = (image_height == '0) ? IMG_W'(1)  : image_height;
  assign dw = (dest_width   == '0) ? DEST_W'(1) : dest_width;
  assign dh = (dest_height  == '0) ? DEST_W'(1) : dest_height;

  // rows padded to 32 bits
  assign iw_round = {1'b0, iw} + (IMG_W + 1)'(31);

  assign size_write = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                                 (cfg_index == REG_IMAGE_HEIGHT) ||
                                 (cfg_index == REG_DEST_WIDTH) ||
                                 (cfg_index == REG_DEST_HEIGHT));

  // step recompute sequencer
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = {iw, FRAC_W'(0)};
    div_divisor  = dw;
    case (state)
      SEQ_IDLE: begin
        if (recalc) begin
          div_start  = 1'b1;
          state_next = SEQ_X;
        end
      end
      SEQ_X: begin
        div_dividend = {ih, FRAC_W'(0)};
        div_divisor  = dh;
        if (div_stat.done) begin
          div_start  = 1'b1;
          state_next = SEQ_Y;
        end
      end
      SEQ_Y: begin
        if (div_stat.done) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SEQ_IDLE;
      recalc <= 1'b0;
      step_x <= STEP_W'(256);
      step_y <= STEP_W'(256);
    end else begin
      state <= state_next;
      if (size_write) recalc <= 1'b1;
      else if (state == SEQ_IDLE) recalc <= 1'b0;
      if (state == SEQ_X && div_stat.done) step_x <= div_q;
      if (state == SEQ_Y && div_stat.done) step_y <= div_q;
    end
  end

  mbsa_step_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // settings bundle for the pipeline
  always_comb begin
    cfg.iw          = iw;
    cfg.ih          = ih;
    cfg.row_bytes   = {iw_round[IMG_W:5], 2'b00};
    cfg.bottom_up   = bottom_up;
    cfg.data_offset = data_offset;
    cfg.origin_x    = origin_x;
    cfg.origin_y    = origin_y;
    cfg.step_x      = step_x;
    cfg.step_y      = step_y;
  end

  mbsa_addr_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept_en (state == SEQ_IDLE && !recalc),
    .pix       (pix),
    .addr      (addr)
  );

  // input is held off during a recompute
  a_hold_while_div: assert property (@(posedge clk) disable iff (rst)
    state != SEQ_IDLE |-> !pix.ready)
    else $error("input ready during step recompute");

  // a size write always leads into a recompute
  a_write_recalc: assert property (@(posedge clk) disable iff (rst)
    size_write |=> recalc)
    else $error("size write did not schedule recompute");

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking bench for mono_bmp_scaled_pixel_address: directed table, then random phases
// needs mbsa_pkg, mbsa_if and the block's rtl; expected words come from an in-bench predictor
`default_nettype none

module tb;
  import mbsa_pkg::*;

  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  LONG_HOLD    = 300;
  localparam int  RAND_PHASES  = 10;
  localparam int  PHASE_ITEMS  = 80;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  DIR_ROWS     = 22;

  // one output word of the block
  typedef struct packed {
    logic [ADDR_W-1:0]  byte_address;
    logic [BIT_W-1:0]   bit_select;
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic               on_screen;
  } pixel_addr_t;

  // full register set of one card setting
  typedef struct packed {
    logic [IMG_W-1:0]   iw;
    logic [IMG_W-1:0]   ih;
    logic               bu;
    logic [ADDR_W-1:0]  off;
    logic [DEST_W-1:0]  dw;
    logic [DEST_W-1:0]  dh;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
  } card_cfg_t;

  // directed stimulus row; typed rows carry their own expected word
  typedef struct packed {
    logic [3:0]        setting;
    logic [DEST_W-1:0] col;
    logic [DEST_W-1:0] row;
    logic              typed;
    pixel_addr_t       exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mbsa_pix_if  pix ();
  mbsa_addr_if addr ();

  mono_bmp_scaled_pixel_address dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .addr      (addr)
  );

  pixel_addr_t expected_addrs [$];
  pixel_addr_t want;
  card_cfg_t   card;
  int          err_count = 0;
  int          cycle_count = 0;
  logic        no_idle = 1'b0;
  logic        long_hold_req = 1'b0;

  // settings of the directed part; entry 0 is the reset state
  card_cfg_t dir_cards [5] = '{
    '{12'd1, 12'd1, 1'b1, 32'h0000_0000, 10'd1, 10'd1, 16'h0000, 16'h0000},
    '{12'd4095, 12'd4095, 1'b0, 32'hFFFF_FFF0, 10'd1, 10'd1, 16'h7FFF, 16'h8000},
    '{12'd0, 12'd0, 1'b1, 32'h1234_5678, 10'd0, 10'd0, 16'hFFFB, 16'hFFFF},
    '{12'd640, 12'd400, 1'b1, 32'h0000_003E, 10'd1023, 10'd1023, 16'h0000, 16'h0000},
    '{12'd33, 12'd7, 1'b0, 32'h0000_0100, 10'd3, 10'd2, 16'd790, 16'd470}
  };

  dir_row_t directed [DIR_ROWS] = '{
    // reset settings: every source lookup lands on byte 0, bit 7
    '{4'd0, 10'd0,    10'd0,    1'b1, '{32'h0, 3'd7, 16'h0000, 16'h0000, 1'b1}},
    '{4'd0, 10'd1023, 10'd1023, 1'b1, '{32'h0, 3'd7, 16'h03FF, 16'h03FF, 1'b0}},
    '{4'd0, 10'd799,  10'd479,  1'b1, '{32'h0, 3'd7, 16'h031F, 16'h01DF, 1'b1}},
    '{4'd0, 10'd800,  10'd0,    1'b1, '{32'h0, 3'd7, 16'h0320, 16'h0000, 1'b0}},
    '{4'd0, 10'd0,    10'd480,  1'b1, '{32'h0, 3'd7, 16'h0000, 16'h01E0, 1'b0}},
    '{4'd0, 10'd512,  10'd341,  1'b1, '{32'h0, 3'd7, 16'h0200, 16'h0155, 1'b1}},
    // largest image, address and screen wrap
    '{4'd1, 10'd0,    10'd0,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd1, 10'd1023, 10'd1023, 1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd1, 10'd1,    10'd1,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd1, 10'd0,    10'd1023, 1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    // zero image and card sizes act as one
    '{4'd2, 10'd0,    10'd0,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd2, 10'd5,    10'd1,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd2, 10'd1023, 10'd2,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    // upscaled, bottom-up, screen edges
    '{4'd3, 10'd0,    10'd0,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd3, 10'd1022, 10'd1022, 1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd3, 10'd639,  10'd399,  1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd3, 10'd800,  10'd480,  1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd3, 10'd1023, 10'd0,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    // indexes past the card clamp to the last image column and row
    '{4'd4, 10'd2,    10'd1,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd4, 10'd3,    10'd2,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd4, 10'd600,  10'd900,  1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}},
    '{4'd4, 10'd9,    10'd9,    1'b0, '{32'h0, 3'd0, 16'h0, 16'h0, 1'b0}}
  };

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // source index: (idx * 12.8 step) >> 8, clamped to the last pixel
  function automatic logic [31:0] scaled_index(logic [DEST_W-1:0] idx, logic [IMG_W-1:0] size,
                                               logic [DEST_W-1:0] dsize);
    logic [63:0] step;
    logic [63:0] s;
    step = (64'(size) * 64'd256) / 64'(dsize);
    s = (64'(idx) * step) >> 8;
    if (s >= 64'(size)) s = 64'(size) - 64'd1;
    return s[31:0];
  endfunction

  // expected word for one destination pixel under the current card setting
  function automatic pixel_addr_t predict_source_addr(logic [DEST_W-1:0] col,
                                                      logic [DEST_W-1:0] row);
    logic [IMG_W-1:0]  iw;
    logic [IMG_W-1:0]  ih;
    logic [DEST_W-1:0] dw;
    logic [DEST_W-1:0] dh;
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       row_bytes;
    logic [31:0]       file_row;
    pixel_addr_t       p;
    iw = (card.iw == '0) ? IMG_W'(1) : card.iw;
    ih = (card.ih == '0) ? IMG_W'(1) : card.ih;
    dw = (card.dw == '0) ? DEST_W'(1) : card.dw;
    dh = (card.dh == '0) ? DEST_W'(1) : card.dh;
    row_bytes = ((32'(iw) + 32'd31) / 32'd32) * 32'd4;
    sx = scaled_index(col, iw, dw);
    sy = scaled_index(row, ih, dh);
    file_row = card.bu ? (32'(ih) - 32'd1 - sy) : sy;
    p.byte_address = card.off + file_row * row_bytes + (sx >> 3);
    p.bit_select   = 3'd7 - sx[2:0];
    p.screen_x     = card.ox + COORD_W'(col);
    p.screen_y     = card.oy + COORD_W'(row);
    p.on_screen    = !p.screen_x[COORD_W-1] && (p.screen_x < COORD_W'(SCREEN_WIDTH)) &&
                     !p.screen_y[COORD_W-1] && (p.screen_y < COORD_W'(SCREEN_HEIGHT));
    return p;
  endfunction

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // image or card size with the extremes weighted in
  function automatic int pick_size(int maxv);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return maxv;
    if (r < 10) return $urandom_range(1, 64);
    return $urandom_range(1, maxv);
  endfunction

  function automatic logic [COORD_W-1:0] pick_origin();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if (r < 12) return COORD_W'($urandom_range(0, 1100) - 150);
    return COORD_W'($urandom());
  endfunction

  function automatic card_cfg_t random_card();
    card_cfg_t c;
    c.iw  = IMG_W'(pick_size(4095));
    c.ih  = IMG_W'(pick_size(4095));
    c.bu  = 1'($urandom_range(0, 1));
    c.off = $urandom_range(0, 3) == 0 ? 32'hFFFF_FF00 + 32'($urandom_range(0, 255)) : $urandom();
    c.dw  = DEST_W'(pick_size(1023));
    c.dh  = DEST_W'(pick_size(1023));
    c.ox  = pick_origin();
    c.oy  = pick_origin();
    return c;
  endfunction

  // destination index: mostly inside the card, some anywhere in the field
  function automatic logic [DEST_W-1:0] pick_index(logic [DEST_W-1:0] dsize);
    int eff;
    eff = (dsize == '0) ? 1 : int'(dsize);
    if ($urandom_range(0, 99) < 85) return DEST_W'($urandom_range(0, eff - 1));
    return DEST_W'($urandom_range(0, 1023));
  endfunction

  // one register write; unused upper data bits carry noise
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val, int w);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = ($urandom() << w) | val;
    @(negedge clk);
  endtask

  task automatic apply_card(card_cfg_t c);
    write_reg(REG_IMAGE_WIDTH,  32'(c.iw),  IMG_W);
    write_reg(REG_IMAGE_HEIGHT, 32'(c.ih),  IMG_W);
    write_reg(REG_BOTTOM_UP,    32'(c.bu),  1);
    write_reg(REG_DATA_OFFSET,  c.off,      ADDR_W);
    write_reg(REG_DEST_WIDTH,   32'(c.dw),  DEST_W);
    write_reg(REG_DEST_HEIGHT,  32'(c.dh),  DEST_W);
    write_reg(REG_ORIGIN_X,     32'(c.ox),  COORD_W);
    write_reg(REG_ORIGIN_Y,     32'(c.oy),  COORD_W);
    cfg_we = 1'b0;
    card = c;
  endtask

  // drop valid and wait for every expected word; returns on a falling edge
  task automatic wait_drained();
    pix.valid = 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // offer one pixel word; called and returning on a falling edge
  task automatic send_pix(logic [DEST_W-1:0] col, logic [DEST_W-1:0] row, logic typed,
                          pixel_addr_t typed_exp);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid    = 1'b1;
    pix.dest_col = col;
    pix.dest_row = row;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    expected_addrs.push_back(typed ? typed_exp : predict_source_addr(col, row));
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      err_count++;
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    addr.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : pick_gap();
      if (long_hold_req) begin
        addr.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (gap > 0) begin
        addr.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      addr.ready = 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // output word check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && addr.valid && addr.ready) begin
      if (expected_addrs.size() == 0) begin
        $error("unexpected word: byte_address %h", addr.byte_address);
        err_count++;
      end else begin
        want = expected_addrs.pop_front();
        check_field("byte_address", want.byte_address, addr.byte_address);
        check_field("bit_select", {29'h0, want.bit_select}, {29'h0, addr.bit_select});
        check_field("screen_x", {16'h0, want.screen_x}, {16'h0, addr.screen_x});
        check_field("screen_y", {16'h0, want.screen_y}, {16'h0, addr.screen_y});
        check_field("on_screen", {31'h0, want.on_screen}, {31'h0, addr.on_screen});
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin
    int cur;
    int ph;
    int k;
    logic [DEST_W-1:0] col;
    logic [DEST_W-1:0] row;
    pix.valid    = 1'b0;
    pix.dest_col = '0;
    pix.dest_row = '0;
    card = dir_cards[0];
    cur = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed table
    for (k = 0; k < DIR_ROWS; k++) begin
      if (int'(directed[k].setting) != cur) begin
        wait_drained();
        cur = int'(directed[k].setting);
        apply_card(dir_cards[cur]);
      end
      send_pix(directed[k].col, directed[k].row, directed[k].typed, directed[k].exp);
    end

    // random phases, each under a new card setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      apply_card(random_card());
      no_idle = (ph == 3) || (ph == 6);
      if (ph == 3) long_hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 8 && k == PHASE_ITEMS / 2) wait_drained();
        col = pick_index(card.dw);
        row = pick_index(card.dh);
        send_pix(col, row, 1'b0, '0);
      end
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
